[hw/rtl/tpife_pkg.sv]
// tpife_pkg: shared types and constants for the TPI host frame engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpife_pkg;

    localparam int unsigned FRAME_BITS   = 12;
    localparam int unsigned BIT_CNT_W    = 4;
    localparam int unsigned IDLE_CNT_W   = 4;
    localparam int unsigned HUNT_CNT_W   = 8;
    localparam int unsigned CFG_DATA_W   = 8;

    localparam logic [IDLE_CNT_W-1:0] LEAD_IDLE_RESET  = 4'd2;
    localparam logic [HUNT_CNT_W-1:0] HUNT_LIMIT_RESET = 8'd20;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SEND  = 2'd1,
        OP_RECV  = 2'd2,
        OP_BREAK = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TIMEOUT    = 2'd1,
        ST_STOP_ERR   = 2'd2,
        ST_PARITY_ERR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SHIFT = 2'd1,
        MODE_HUNT  = 2'd2,
        MODE_RX    = 2'd3
    } mode_t;

    typedef enum logic {
        REG_LEAD_IDLE  = 1'b0,
        REG_HUNT_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] tx_byte;
        logic       line_in;
    } item_t;

    typedef struct packed {
        logic       clock_pulse;
        logic       data_out;
        logic       drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic [1:0] status;
    } result_t;

endpackage

[hw/rtl/tpi_host_frame_engine_unit.sv]
// TPI host frame engine: host link layer, one link clock cycle per item.
// Depends on tpife_pkg and tpife_link.
//
// Usage:
//   Input channel (s_*): one item per link clock cycle. opcode starts a send,
//   receive or break while idle; otherwise the item is a plain tick.
//   line_in carries the data line level sampled after that cycle's edge.
//   Result channel (m_*): exactly one result per item, in order: clock
//   pulse, driven data level, drive enable, busy/done and receive status.
//   Config port: cfg_we writes cfg_wdata to register cfg_index
//   (0 lead idle bits, 1 start hunt limit); write only while idle.
// Timing:
//   Each item passes the input register, then the result register, before
//   m_valid rises. Throughput is one item per cycle while m_ready stays
//   high; the single link step between the two registers sets that figure.
//   When m_ready is low, the result register holds and the input register
//   takes one more item before s_ready drops.
//   Synchronous reset empties both registers, returns the link to idle and
//   loads the register defaults (2 lead idle bits, hunt limit 20).
`timescale 1ns / 1ps

module tpi_host_frame_engine_unit
    import tpife_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [7:0]            s_tx_byte,
    input  logic                  s_line_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_clock_pulse,
    output logic                  m_data_out,
    output logic                  m_drive_enable,
    output logic                  m_busy_res,
    output logic                  m_done_res,
    output logic [7:0]            m_rx_byte,
    output logic [1:0]            m_status
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t step_res;
    logic    advance;
    logic    s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    tpife_link u_link (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (advance),
        .item       (in_item_reg),
        .result     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= '{opcode: s_opcode, tx_byte: s_tx_byte, line_in: s_line_in};
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_clock_pulse  = out_res_reg.clock_pulse;
    assign m_data_out     = out_res_reg.data_out;
    assign m_drive_enable = out_res_reg.drive_enable;
    assign m_busy_res     = out_res_reg.busy_res;
    assign m_done_res     = out_res_reg.done_res;
    assign m_rx_byte      = out_res_reg.rx_byte;
    assign m_status       = out_res_reg.status;

endmodule

[hw/rtl/tpife_link.sv]
// tpife_link: link-layer state, configuration registers and per-item step logic.
// Depends on tpife_pkg.
`timescale 1ns / 1ps

module tpife_link
    import tpife_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  item_valid,
    input  item_t                 item,
    output result_t               result
);

    mode_t                  mode_reg,  mode_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [BIT_CNT_W-1:0]   bit_reg,   bit_next;
    logic [IDLE_CNT_W-1:0]  idle_reg,  idle_next;
    logic [HUNT_CNT_W-1:0]  hunt_reg,  hunt_next;
    logic                   lws_reg,   lws_next;
    logic [IDLE_CNT_W-1:0]  lead_idle_reg;
    logic [HUNT_CNT_W-1:0]  hunt_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_idle_reg  <= LEAD_IDLE_RESET;
            hunt_limit_reg <= HUNT_LIMIT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_LEAD_IDLE) begin
                lead_idle_reg <= cfg_wdata[IDLE_CNT_W-1:0];
            end else begin
                hunt_limit_reg <= cfg_wdata[HUNT_CNT_W-1:0];
            end
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        frame_next = frame_reg;
        bit_next   = bit_reg;
        idle_next  = idle_reg;
        hunt_next  = hunt_reg;
        lws_next   = lws_reg;
        result     = '0;

        // command decode, only taken while idle
        if (mode_reg == MODE_IDLE) begin
            case (opcode_t'(item.opcode))
                OP_SEND: begin
                    frame_next = {2'b11, ^item.tx_byte, item.tx_byte, 1'b0};
                    idle_next  = lws_reg ? '0 : lead_idle_reg;
                    bit_next   = '0;
                    lws_next   = 1'b1;
                    mode_next  = MODE_SHIFT;
                end
                OP_BREAK: begin
                    frame_next = '0;
                    idle_next  = '0;
                    bit_next   = '0;
                    mode_next  = MODE_SHIFT;
                end
                OP_RECV: begin
                    lws_next  = 1'b0;
                    hunt_next = '0;
                    mode_next = MODE_HUNT;
                end
                default: ;
            endcase
        end

        case (mode_next)
            MODE_SHIFT: begin
                result.clock_pulse  = 1'b1;
                result.drive_enable = 1'b1;
                if (idle_next != '0) begin
                    result.data_out = 1'b1;
                    idle_next       = idle_next - 1'b1;
                end else begin
                    result.data_out = (bit_next < BIT_CNT_W'(FRAME_BITS)) ?
                                      frame_next[bit_next] : 1'b1;
                    bit_next = bit_next + 1'b1;
                    if (bit_next >= BIT_CNT_W'(FRAME_BITS)) begin
                        result.done_res = 1'b1;
                        mode_next       = MODE_IDLE;
                    end
                end
            end
            MODE_HUNT: begin
                result.clock_pulse = 1'b1;
                hunt_next = hunt_next + 1'b1;
                if (!item.line_in) begin
                    mode_next  = MODE_RX;
                    bit_next   = '0;
                    frame_next = '0;
                end else if (hunt_next == hunt_limit_reg) begin
                    result.done_res = 1'b1;
                    result.status   = ST_TIMEOUT;
                    mode_next       = MODE_IDLE;
                end
            end
            MODE_RX: begin
                result.clock_pulse = 1'b1;
                if (bit_next < BIT_CNT_W'(FRAME_BITS)) begin
                    frame_next[bit_next] = item.line_in;
                end
                bit_next = bit_next + 1'b1;
                if (bit_next >= BIT_CNT_W'(FRAME_BITS)) begin
                    result.done_res = 1'b1;
                    mode_next       = MODE_IDLE;
                    if (frame_next[10:9] != 2'b11) begin
                        result.status = ST_STOP_ERR;
                    end else if ((^frame_next[7:0]) != frame_next[8]) begin
                        result.status = ST_PARITY_ERR;
                    end else begin
                        result.rx_byte = frame_next[7:0];
                    end
                end
            end
            default: ;
        endcase

        result.busy_res = (mode_next != MODE_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            frame_reg <= '0;
            bit_reg   <= '0;
            idle_reg  <= '0;
            hunt_reg  <= '0;
            lws_reg   <= 1'b0;
        end else if (item_valid) begin
            mode_reg  <= mode_next;
            frame_reg <= frame_next;
            bit_reg   <= bit_next;
            idle_reg  <= idle_next;
            hunt_reg  <= hunt_next;
            lws_reg   <= lws_next;
        end
    end

endmodule

[hw/rtl/tpife_checker.sv]
// tpife_checker: port-level assertions for tpi_host_frame_engine_unit.
// Depends on tpife_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module tpife_checker
    import tpife_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_clock_pulse,
    input logic       m_data_out,
    input logic       m_drive_enable,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_rx_byte,
    input logic [1:0] m_status
);

    // stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_rx_byte)
            && $stable(m_done_res) && $stable(m_busy_res))
        else $error("stalled result item changed");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done and busy together");

    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK || m_rx_byte != 8'd0) |-> m_done_res && m_clock_pulse)
        else $error("status or data outside a finished receive");

    a_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data_out || m_drive_enable) |-> m_drive_enable && m_clock_pulse
            && m_status == ST_OK)
        else $error("driven data without a clocked send cycle");

endmodule

bind tpi_host_frame_engine_unit tpife_checker u_tpife_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_clock_pulse  (m_clock_pulse),
    .m_data_out     (m_data_out),
    .m_drive_enable (m_drive_enable),
    .m_busy_res     (m_busy_res),
    .m_done_res     (m_done_res),
    .m_rx_byte      (m_rx_byte),
    .m_status       (m_status)
);

[tb/tpife_frame_checker.sv]
// tpife_frame_checker: result predictor and scoreboard for the TPI host frame engine.
// Watches the config port and both item channels; depends on tpife_pkg only.
`timescale 1ns / 1ps

module tpife_frame_checker
    import tpife_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [7:0]            s_tx_byte,
    input  logic                  s_line_in,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_clock_pulse,
    input  logic                  m_data_out,
    input  logic                  m_drive_enable,
    input  logic                  m_busy_res,
    input  logic                  m_done_res,
    input  logic [7:0]            m_rx_byte,
    input  logic [1:0]            m_status,
    output int unsigned           fail_count,
    output int unsigned           results_owed,
    output logic                  link_idle,
    output logic                  link_sent_last
);

    mode_t                 link_mode;
    logic [11:0]           frame_bits;
    logic [4:0]            bit_idx;
    logic [3:0]            idle_left;
    logic [7:0]            hunt_cnt;
    logic                  after_send;
    logic [3:0]            lead_cfg;
    logic [7:0]            hunt_cfg;
    result_t               link_results[$];
    int unsigned           shown;

    assign link_idle      = (link_mode == MODE_IDLE);
    assign link_sent_last = after_send;

    function automatic result_t step_link(input logic [1:0] op, input logic [7:0] tx,
                                          input logic line);
        result_t    r;
        logic [3:0] pos;
        r = '0;
        if (link_mode == MODE_IDLE && op != OP_TICK) begin
            case (op)
                OP_SEND: begin
                    frame_bits = {2'b11, ^tx, tx, 1'b0};
                    idle_left  = after_send ? 4'd0 : lead_cfg;
                    bit_idx    = '0;
                    after_send = 1'b1;
                    link_mode  = MODE_SHIFT;
                end
                OP_BREAK: begin
                    frame_bits = '0;
                    idle_left  = '0;
                    bit_idx    = '0;
                    link_mode  = MODE_SHIFT;
                end
                default: begin
                    after_send = 1'b0;
                    hunt_cnt   = '0;
                    link_mode  = MODE_HUNT;
                end
            endcase
        end
        case (link_mode)
            MODE_SHIFT: begin
                r.clock_pulse  = 1'b1;
                r.drive_enable = 1'b1;
                if (idle_left != 0) begin
                    r.data_out = 1'b1;
                    idle_left  = idle_left - 4'd1;
                end else begin
                    pos        = bit_idx[3:0];
                    r.data_out = (pos < FRAME_BITS) ? frame_bits[pos] : 1'b1;
                    bit_idx    = bit_idx + 5'd1;
                    if (bit_idx >= FRAME_BITS) begin
                        r.done_res = 1'b1;
                        link_mode  = MODE_IDLE;
                    end
                end
            end
            MODE_HUNT: begin
                r.clock_pulse = 1'b1;
                hunt_cnt      = hunt_cnt + 8'd1;
                if (!line) begin
                    link_mode  = MODE_RX;
                    bit_idx    = '0;
                    frame_bits = '0;
                end else if (hunt_cnt == hunt_cfg) begin
                    r.done_res = 1'b1;
                    r.status   = ST_TIMEOUT;
                    link_mode  = MODE_IDLE;
                end
            end
            MODE_RX: begin
                pos           = bit_idx[3:0];
                r.clock_pulse = 1'b1;
                if (pos < FRAME_BITS)
                    frame_bits = frame_bits | (12'(line) << pos);
                bit_idx = bit_idx + 5'd1;
                if (bit_idx >= FRAME_BITS) begin
                    r.done_res = 1'b1;
                    link_mode  = MODE_IDLE;
                    if (frame_bits[10:9] != 2'b11)
                        r.status = ST_STOP_ERR;
                    else if ((^frame_bits[7:0]) != frame_bits[8])
                        r.status = ST_PARITY_ERR;
                    else
                        r.rx_byte = frame_bits[7:0];
                end
            end
            default: ;
        endcase
        r.busy_res = (link_mode != MODE_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (shown < 100) begin
                shown++;
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    initial begin
        fail_count   = 0;
        results_owed = 0;
        shown        = 0;
        link_mode    = MODE_IDLE;
        after_send   = 1'b0;
    end

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            link_mode  = MODE_IDLE;
            frame_bits = '0;
            bit_idx    = '0;
            idle_left  = '0;
            hunt_cnt   = '0;
            after_send = 1'b0;
            lead_cfg   = LEAD_IDLE_RESET;
            hunt_cfg   = HUNT_LIMIT_RESET;
            link_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_LEAD_IDLE)
                    lead_cfg = cfg_wdata[3:0];
                else
                    hunt_cfg = cfg_wdata[7:0];
            end
            if (s_valid && s_ready)
                link_results.push_back(step_link(s_opcode, s_tx_byte, s_line_in));
            if (m_valid && m_ready) begin
                if (link_results.size() == 0) begin
                    fail_count++;
                    if (shown < 100) begin
                        shown++;
                        $display("%0t ns: result with none expected, got %0h", $time,
                                 {m_clock_pulse, m_data_out, m_drive_enable, m_busy_res,
                                  m_done_res, m_rx_byte, m_status});
                    end
                end else begin
                    want = link_results.pop_front();
                    check_field("clock_pulse", want.clock_pulse, m_clock_pulse);
                    check_field("data_out", want.data_out, m_data_out);
                    check_field("drive_enable", want.drive_enable, m_drive_enable);
                    check_field("busy_res", want.busy_res, m_busy_res);
                    check_field("done_res", want.done_res, m_done_res);
                    check_field("rx_byte", want.rx_byte, m_rx_byte);
                    check_field("status", want.status, m_status);
                end
            end
        end
        results_owed = link_results.size();
    end

endmodule

[tb/tb.sv]
// tb: top of the TPI host frame engine testbench; builds sends, breaks, receives
// with scripted line levels and noise under several config and stall phases.
// Depends on tpife_pkg, tpi_host_frame_engine_unit and tpife_frame_checker.
`timescale 1ns / 1ps

module tb;
    import tpife_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_opcode = '0;
    logic [7:0]            s_tx_byte = '0;
    logic                  s_line_in = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_clock_pulse;
    logic                  m_data_out;
    logic                  m_drive_enable;
    logic                  m_busy_res;
    logic                  m_done_res;
    logic [7:0]            m_rx_byte;
    logic [1:0]            m_status;
    int unsigned           fail_count;
    int unsigned           results_owed;
    logic                  link_idle;
    logic                  link_sent_last;

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent = 0;
    logic [3:0]  lead_now = LEAD_IDLE_RESET;
    logic [7:0]  hunt_now = HUNT_LIMIT_RESET;
    logic        prev_send = 1'b0;

    tpi_host_frame_engine_unit DUT (.*);
    tpife_frame_checker u_check (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    task automatic push_item(input logic [1:0] op, input logic [7:0] tx, input logic line);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_tx_byte <= tx;
        s_line_in <= line;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // opcode is ignored while the link is busy
    task automatic push_filler();
        push_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (!link_idle) begin
            push_item(OP_TICK, 8'($urandom), 1'($urandom));
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        prev_send = link_sent_last;
    endtask

    task automatic set_regs(input logic [3:0] lead, input logic [7:0] hunt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LEAD_IDLE;
        cfg_wdata <= CFG_DATA_W'(lead);
        @(posedge aclk);
        cfg_index <= REG_HUNT_LIMIT;
        cfg_wdata <= hunt;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        lead_now = lead;
        hunt_now = hunt;
    endtask

    function automatic int unsigned hunt_span();
        return (hunt_now == 0) ? 256 : hunt_now;
    endfunction

    task automatic send_op(input logic [7:0] tx);
        int unsigned n;
        n = (prev_send ? 0 : lead_now) + FRAME_BITS - 1;
        push_item(OP_SEND, tx, 1'($urandom));
        repeat (n) push_filler();
        prev_send = 1'b1;
    endtask

    task automatic break_op();
        push_item(OP_BREAK, 8'($urandom), 1'($urandom));
        repeat (FRAME_BITS - 1) push_filler();
    endtask

    // fault: 0 clean frame, 1 bad parity, 2 bad stop bits, 3 both
    task automatic recv_op(input int unsigned h, input bit timeout, input logic [7:0] data,
                           input int unsigned fault);
        logic [11:0] frame;
        logic        line;
        int unsigned total;
        frame = {1'($urandom), 2'b11, ^data, data};
        if (fault == 1 || fault == 3)
            frame[8] = ~frame[8];
        if (fault >= 2)
            frame[10:9] = 2'($urandom_range(2));
        total = timeout ? hunt_span() : h + 13;
        for (int unsigned j = 0; j < total; j++) begin
            if (timeout || j < h)
                line = 1'b1;
            else if (j == h)
                line = 1'b0;
            else
                line = frame[j - h - 1];
            if (j == 0)
                push_item(OP_RECV, 8'($urandom), line);
            else
                push_item(2'($urandom_range(3)), 8'($urandom), line);
        end
        prev_send = 1'b0;
    endtask

    task automatic random_recv();
        int unsigned span;
        int unsigned pick;
        int unsigned h;
        int unsigned fault;
        span  = hunt_span();
        pick  = $urandom_range(99);
        if (pick < 70)
            h = $urandom_range((span > 6) ? 5 : span - 1);
        else if (pick < 90)
            h = $urandom_range(span - 1);
        else
            h = span - 1;
        pick  = $urandom_range(99);
        fault = (pick < 70) ? 0 : (pick < 80) ? 1 : (pick < 90) ? 2 : 3;
        recv_op(h, $urandom_range(99) < 6, 8'($urandom), fault);
    endtask

    task automatic run_phase(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_op(($urandom_range(9) == 0) ? 8'($urandom_range(1) * 8'hFF)
                                                 : 8'($urandom));
            else if (pick < 50)
                break_op();
            else if (pick < 85)
                random_recv();
            else if (pick < 90)
                repeat ($urandom_range(1, 3)) push_item(OP_TICK, 8'($urandom), 1'($urandom));
            else begin
                repeat ($urandom_range(5, 20)) push_filler();
                settle();
            end
        end
    endtask

    initial begin
        int unsigned lead_set[4] = '{4'd0, 4'd15, 4'd7, 4'd3};
        int unsigned hunt_set[4] = '{8'd1, 8'd255, 8'd0, 8'd9};
        int unsigned gap_set[4]  = '{0, 88, 0, 19};
        int unsigned stall_set[4] = '{0, 0, 88, 19};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset defaults
        push_item(OP_TICK, 8'hFF, 1'b1);
        send_op(8'h00);
        send_op(8'hFF);
        break_op();
        send_op(8'h5A);
        recv_op(0, 0, 8'hA5, 0);
        send_op(8'h3C);
        recv_op(hunt_span() - 1, 0, 8'h81, 0);
        recv_op(0, 1, 8'h00, 0);
        recv_op(2, 0, 8'h0F, 2);
        recv_op(1, 0, 8'hF0, 1);
        recv_op(0, 0, 8'h77, 3);
        recv_op(0, 0, 8'hFF, 0);
        recv_op(0, 0, 8'h00, 0);
        settle();

        for (int p = 0; p < 4; p++) begin
            set_regs(4'(lead_set[p]), 8'(hunt_set[p]));
            gap_pct   = gap_set[p];
            stall_pct = stall_set[p];
            if (p == 0)
                send_op(8'hC3);
            run_phase(380);
            settle();
        end

        stall_pct = 0;
        while (results_owed != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tpife_pkg.sv
hw/rtl/tpife_link.sv
hw/rtl/tpi_host_frame_engine_unit.sv
hw/rtl/tpife_checker.sv
tb/tpife_frame_checker.sv
tb/tb.sv
